// ===== design/tps_pkg.sv =====
`default_nettype none
package tps_pkg;

    localparam int COORD_BITS = 32;
    localparam int EDGE_BITS = 32;
    localparam int KIND_BITS = 2;

    localparam logic [KIND_BITS-1:0] KIND_NONE  = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_PAIR  = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_ALL   = 2'd2;
    localparam logic [KIND_BITS-1:0] KIND_CROSS = 2'd3;

endpackage
`default_nettype wire

// ===== design/tps_front.sv =====
`default_nettype none
module tps_front #(
    parameter int CB = tps_pkg::COORD_BITS
) (
    input  wire logic signed [CB-1:0]                  corner_a_x,
    input  wire logic signed [CB-1:0]                  corner_a_y,
    input  wire logic signed [CB-1:0]                  corner_a_z,
    input  wire logic signed [CB-1:0]                  corner_b_x,
    input  wire logic signed [CB-1:0]                  corner_b_y,
    input  wire logic signed [CB-1:0]                  corner_b_z,
    input  wire logic signed [CB-1:0]                  corner_c_x,
    input  wire logic signed [CB-1:0]                  corner_c_y,
    input  wire logic signed [CB-1:0]                  corner_c_z,
    output logic                                       job_valid,
    output logic [tps_pkg::KIND_BITS+9*CB-1:0]         job_data
);

    localparam int PW = 3 * CB;

    logic [PW-1:0] pa;
    logic [PW-1:0] pb;
    logic [PW-1:0] pc;
    logic          oa;
    logic          ob;
    logic          oc;
    logic          na;
    logic          nb;
    logic          nc;
    logic [1:0]    on_count;
    logic [tps_pkg::KIND_BITS-1:0] kind;
    logic [PW-1:0] pt0;
    logic [PW-1:0] pt1;
    logic [PW-1:0] pt2;

    assign pa = {corner_a_x, corner_a_y, corner_a_z};
    assign pb = {corner_b_x, corner_b_y, corner_b_z};
    assign pc = {corner_c_x, corner_c_y, corner_c_z};
    assign oa = (corner_a_z == '0);
    assign ob = (corner_b_z == '0);
    assign oc = (corner_c_z == '0);
    assign na = corner_a_z[CB-1];
    assign nb = corner_b_z[CB-1];
    assign nc = corner_c_z[CB-1];
    assign on_count = {1'b0, oa} + {1'b0, ob} + {1'b0, oc};

    always_comb
    begin
        kind = tps_pkg::KIND_NONE;
        pt0 = pa;
        pt1 = pb;
        pt2 = pc;
        case (on_count)
            2'd2:
            begin
                kind = tps_pkg::KIND_PAIR;
                if (!oa)
                begin
                    pt0 = pb;
                    pt1 = pc;
                end
                else if (!ob)
                begin
                    pt0 = pa;
                    pt1 = pc;
                end
                else
                begin
                    pt0 = pb;
                    pt1 = pa;
                end
            end
            2'd3:
            begin
                kind = tps_pkg::KIND_ALL;
            end
            2'd0:
            begin
                if ((na == nb) && (na == nc))
                begin
                    kind = tps_pkg::KIND_NONE;
                end
                else
                begin
                    kind = tps_pkg::KIND_CROSS;
                    if ((na != nb) && (na != nc))
                    begin
                        pt0 = pa;
                        pt1 = pb;
                        pt2 = pc;
                    end
                    else if (nb != na)
                    begin
                        pt0 = pb;
                        pt1 = pa;
                        pt2 = pc;
                    end
                    else
                    begin
                        pt0 = pc;
                        pt1 = pb;
                        pt2 = pa;
                    end
                end
            end
            default:
            begin
                kind = tps_pkg::KIND_NONE;
            end
        endcase
    end

    assign job_valid = (kind != tps_pkg::KIND_NONE);
    assign job_data = {kind, pt0, pt1, pt2};

endmodule
`default_nettype wire

// ===== design/tps_queue.sv =====
`default_nettype none
module tps_queue #(
    parameter int WIDTH = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             pop,
    output logic                  full,
    output logic                  empty,
    output logic [WIDTH-1:0]      rdata
);

    logic [WIDTH-1:0] mem_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;
    logic             do_push;
    logic             do_pop;

    assign full = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign rdata = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop = pop && !empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule
`default_nettype wire

// ===== design/tps_cut.sv =====
`default_nettype none
module tps_cut #(
    parameter int CB = tps_pkg::COORD_BITS
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [CB-1:0] mcand,
    input  wire logic [CB:0]   mplier,
    input  wire logic [CB:0]   divisor,
    output logic               fin,
    output logic [CB-1:0]      mag
);

    localparam int CW = $clog2(CB + 1);
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_MUL  = 2'd1;
    localparam logic [1:0] PH_DIV  = 2'd2;
    localparam logic [1:0] PH_DONE = 2'd3;

    logic [1:0]    phase_reg;
    logic [1:0]    phase_next;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;
    logic [2*CB:0] acc_reg;
    logic [2*CB:0] acc_next;
    logic [CB-1:0] mcand_reg;
    logic [CB-1:0] mcand_next;
    logic [CB:0]   mplier_reg;
    logic [CB:0]   mplier_next;
    logic [CB:0]   div_reg;
    logic [CB:0]   div_next;
    logic [CB-1:0] q_reg;
    logic [CB-1:0] q_next;
    logic [CB+1:0] trial;
    logic [CB+1:0] rem;
    logic          ge;

    assign trial = {acc_reg[2*CB:CB], acc_reg[CB-1]};
    assign ge = (trial >= {1'b0, div_reg});
    assign rem = ge ? (trial - {1'b0, div_reg}) : trial;
    assign fin = (phase_reg == PH_DONE);
    assign mag = q_reg;

    always_comb
    begin
        phase_next = phase_reg;
        cnt_next = cnt_reg;
        acc_next = acc_reg;
        mcand_next = mcand_reg;
        mplier_next = mplier_reg;
        div_next = div_reg;
        q_next = q_reg;
        case (phase_reg)
            PH_IDLE, PH_DONE:
            begin
                if (start)
                begin
                    mcand_next = mcand;
                    mplier_next = mplier;
                    div_next = divisor;
                    acc_next = '0;
                    cnt_next = CW'(CB);
                    phase_next = PH_MUL;
                end
            end
            PH_MUL:
            begin
                acc_next = {acc_reg[2*CB-1:0], 1'b0}
                    + (mplier_reg[CB] ? {{(CB+1){1'b0}}, mcand_reg} : '0);
                mplier_next = {mplier_reg[CB-1:0], 1'b0};
                if (cnt_reg == '0)
                begin
                    cnt_next = CW'(CB - 1);
                    phase_next = PH_DIV;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            PH_DIV:
            begin
                acc_next = {rem[CB:0], acc_reg[CB-2:0], 1'b0};
                q_next = {q_reg[CB-2:0], ge};
                if (cnt_reg == '0)
                begin
                    phase_next = PH_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            cnt_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        mcand_reg <= mcand_next;
        mplier_reg <= mplier_next;
        div_reg <= div_next;
        q_reg <= q_next;
    end

endmodule
`default_nettype wire

// ===== design/tps_back.sv =====
`default_nettype none
module tps_back #(
    parameter int CB = tps_pkg::COORD_BITS
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  job_empty,
    input  wire logic [tps_pkg::KIND_BITS+9*CB-1:0]    job_data,
    output logic                                       job_pop,
    input  wire logic                                  pop,
    output logic                                       empty,
    output logic signed [CB-1:0]                       seg_start_x,
    output logic signed [CB-1:0]                       seg_start_y,
    output logic signed [CB-1:0]                       seg_start_z,
    output logic signed [CB-1:0]                       seg_end_x,
    output logic signed [CB-1:0]                       seg_end_y,
    output logic signed [CB-1:0]                       seg_end_z,
    output logic [tps_pkg::EDGE_BITS-1:0]              edge_number,
    output logic                                       last_segment
);

    localparam int PW = 3 * CB;
    localparam int JW = tps_pkg::KIND_BITS + 9 * CB;
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_EMIT  = 2'd1;
    localparam logic [1:0] ST_START = 2'd2;
    localparam logic [1:0] ST_WAIT  = 2'd3;

    logic [1:0]    state_reg;
    logic [1:0]    state_next;
    logic [1:0]    k_reg;
    logic [1:0]    k_next;
    logic [JW-1:0] job_reg;
    logic [JW-1:0] job_next;
    logic [tps_pkg::EDGE_BITS-1:0] edge_reg;
    logic [tps_pkg::EDGE_BITS-1:0] edge_next;
    logic          out_valid_reg;
    logic          out_valid_next;
    logic [PW-1:0] out_s_reg;
    logic [PW-1:0] out_s_next;
    logic [PW-1:0] out_e_reg;
    logic [PW-1:0] out_e_next;
    logic [tps_pkg::EDGE_BITS-1:0] out_edge_reg;
    logic [tps_pkg::EDGE_BITS-1:0] out_edge_next;
    logic          out_last_reg;
    logic          out_last_next;

    logic [tps_pkg::KIND_BITS-1:0] kind;
    logic [PW-1:0] pt0;
    logic [PW-1:0] pt1;
    logic [PW-1:0] pt2;
    logic          slot_free;
    logic          write_out;
    logic          lane_start;
    logic [3:0]    lane_fin;
    logic [CB-1:0] pz;
    logic [CB:0]   pz_w;
    logic [CB-1:0] pz_mag;
    logic          pz_pos;
    logic [CB-1:0] lane_p [4];
    logic [CB-1:0] lane_q [4];
    logic [CB-1:0] lane_qz [4];
    logic [CB-1:0] lane_mag [4];
    logic [CB-1:0] lane_res [4];

    assign kind = job_reg[JW-1:3*PW];
    assign pt0 = job_reg[3*PW-1:2*PW];
    assign pt1 = job_reg[2*PW-1:PW];
    assign pt2 = job_reg[PW-1:0];
    assign pz = pt0[CB-1:0];
    assign pz_w = {pz[CB-1], pz};
    assign pz_mag = pz[CB-1] ? (~pz + 1'b1) : pz;
    assign pz_pos = !pz[CB-1] && (pz != '0);
    assign slot_free = !out_valid_reg || pop;

    assign lane_p[0] = pt0[PW-1:2*CB];
    assign lane_p[1] = pt0[2*CB-1:CB];
    assign lane_p[2] = pt0[PW-1:2*CB];
    assign lane_p[3] = pt0[2*CB-1:CB];
    assign lane_q[0] = pt1[PW-1:2*CB];
    assign lane_q[1] = pt1[2*CB-1:CB];
    assign lane_q[2] = pt2[PW-1:2*CB];
    assign lane_q[3] = pt2[2*CB-1:CB];
    assign lane_qz[0] = pt1[CB-1:0];
    assign lane_qz[1] = pt1[CB-1:0];
    assign lane_qz[2] = pt2[CB-1:0];
    assign lane_qz[3] = pt2[CB-1:0];

    genvar g;
    generate
        for (g = 0; g < 4; g++)
        begin : g_lane
            logic [CB:0] d;
            logic [CB:0] dz;
            logic [CB:0] d_mag;
            logic [CB:0] dz_mag;
            logic        negs;
            logic [CB:0] sum;

            assign d = {lane_q[g][CB-1], lane_q[g]} - {lane_p[g][CB-1], lane_p[g]};
            assign dz = {lane_qz[g][CB-1], lane_qz[g]} - pz_w;
            assign d_mag = d[CB] ? (~d + 1'b1) : d;
            assign dz_mag = dz[CB] ? (~dz + 1'b1) : dz;
            assign negs = pz_pos ^ d[CB] ^ dz[CB];
            assign sum = {lane_p[g][CB-1], lane_p[g]}
                + (negs ? (~{1'b0, lane_mag[g]} + 1'b1) : {1'b0, lane_mag[g]});
            assign lane_res[g] = sum[CB-1:0];

            tps_cut #(
                .CB(CB)
            ) u_cut (
                .clk(clk),
                .rst_n(rst_n),
                .start(lane_start),
                .mcand(pz_mag),
                .mplier(d_mag),
                .divisor(dz_mag),
                .fin(lane_fin[g]),
                .mag(lane_mag[g])
            );
        end
    endgenerate

    always_comb
    begin
        state_next = state_reg;
        k_next = k_reg;
        job_next = job_reg;
        edge_next = edge_reg;
        out_valid_next = out_valid_reg && !pop;
        out_s_next = out_s_reg;
        out_e_next = out_e_reg;
        out_edge_next = out_edge_reg;
        out_last_next = out_last_reg;
        job_pop = 1'b0;
        lane_start = 1'b0;
        write_out = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (!job_empty)
                begin
                    job_pop = 1'b1;
                    job_next = job_data;
                    k_next = 2'd0;
                    if (job_data[JW-1:3*PW] == tps_pkg::KIND_CROSS)
                    begin
                        state_next = ST_START;
                    end
                    else
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    write_out = 1'b1;
                    case (k_reg)
                        2'd0:
                        begin
                            out_s_next = pt0;
                            out_e_next = pt1;
                            out_last_next = (kind == tps_pkg::KIND_PAIR);
                        end
                        2'd1:
                        begin
                            out_s_next = pt1;
                            out_e_next = pt2;
                            out_last_next = 1'b0;
                        end
                        default:
                        begin
                            out_s_next = pt2;
                            out_e_next = pt0;
                            out_last_next = 1'b1;
                        end
                    endcase
                    k_next = k_reg + 2'd1;
                    if (out_last_next)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_START:
            begin
                lane_start = 1'b1;
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (lane_fin[0] && slot_free)
                begin
                    write_out = 1'b1;
                    out_s_next = {lane_res[0], lane_res[1], {CB{1'b0}}};
                    out_e_next = {lane_res[2], lane_res[3], {CB{1'b0}}};
                    out_last_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (write_out)
        begin
            out_valid_next = 1'b1;
            out_edge_next = edge_reg;
            edge_next = edge_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            k_reg <= 2'd0;
            edge_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg <= k_next;
            edge_reg <= edge_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
        out_s_reg <= out_s_next;
        out_e_reg <= out_e_next;
        out_edge_reg <= out_edge_next;
        out_last_reg <= out_last_next;
    end

    assign empty = !out_valid_reg;
    assign seg_start_x = out_s_reg[PW-1:2*CB];
    assign seg_start_y = out_s_reg[2*CB-1:CB];
    assign seg_start_z = out_s_reg[CB-1:0];
    assign seg_end_x = out_e_reg[PW-1:2*CB];
    assign seg_end_y = out_e_reg[2*CB-1:CB];
    assign seg_end_z = out_e_reg[CB-1:0];
    assign edge_number = out_edge_reg;
    assign last_segment = out_last_reg;

endmodule
`default_nettype wire

// ===== design/triangle_plane_slicer.sv =====
// Segments: a transaction is queued, then taken into the back end; segments of corners on the plane
// follow one per cycle while the output slot is free; a crossing segment comes from the cut lanes.
// The four shift-add multiply and restoring divide lanes serve one crossing triangle at a time,
// while the queue takes new triangles until it is full.
// Reset: asynchronous, active low; clears the queue, the edge counter and the output.
`default_nettype none
module triangle_plane_slicer #(
    parameter int COORD_BITS = tps_pkg::COORD_BITS
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          push,
    output logic                               full,
    input  wire logic signed [COORD_BITS-1:0]  corner_a_x,
    input  wire logic signed [COORD_BITS-1:0]  corner_a_y,
    input  wire logic signed [COORD_BITS-1:0]  corner_a_z,
    input  wire logic signed [COORD_BITS-1:0]  corner_b_x,
    input  wire logic signed [COORD_BITS-1:0]  corner_b_y,
    input  wire logic signed [COORD_BITS-1:0]  corner_b_z,
    input  wire logic signed [COORD_BITS-1:0]  corner_c_x,
    input  wire logic signed [COORD_BITS-1:0]  corner_c_y,
    input  wire logic signed [COORD_BITS-1:0]  corner_c_z,
    output logic                               empty,
    input  wire logic                          pop,
    output logic signed [COORD_BITS-1:0]       seg_start_x,
    output logic signed [COORD_BITS-1:0]       seg_start_y,
    output logic signed [COORD_BITS-1:0]       seg_start_z,
    output logic signed [COORD_BITS-1:0]       seg_end_x,
    output logic signed [COORD_BITS-1:0]       seg_end_y,
    output logic signed [COORD_BITS-1:0]       seg_end_z,
    output logic [tps_pkg::EDGE_BITS-1:0]      edge_number,
    output logic                               last_segment
);

    localparam int JW = tps_pkg::KIND_BITS + 9 * COORD_BITS;

    logic          job_valid;
    logic [JW-1:0] job_in;
    logic [JW-1:0] job_out;
    logic          job_empty;
    logic          job_pop;

    tps_front #(
        .CB(COORD_BITS)
    ) u_front (
        .corner_a_x(corner_a_x),
        .corner_a_y(corner_a_y),
        .corner_a_z(corner_a_z),
        .corner_b_x(corner_b_x),
        .corner_b_y(corner_b_y),
        .corner_b_z(corner_b_z),
        .corner_c_x(corner_c_x),
        .corner_c_y(corner_c_y),
        .corner_c_z(corner_c_z),
        .job_valid(job_valid),
        .job_data(job_in)
    );

    tps_queue #(
        .WIDTH(JW)
    ) u_queue (
        .clk(clk),
        .rst_n(rst_n),
        .push(push && job_valid),
        .wdata(job_in),
        .pop(job_pop),
        .full(full),
        .empty(job_empty),
        .rdata(job_out)
    );

    tps_back #(
        .CB(COORD_BITS)
    ) u_back (
        .clk(clk),
        .rst_n(rst_n),
        .job_empty(job_empty),
        .job_data(job_out),
        .job_pop(job_pop),
        .pop(pop),
        .empty(empty),
        .seg_start_x(seg_start_x),
        .seg_start_y(seg_start_y),
        .seg_start_z(seg_start_z),
        .seg_end_x(seg_end_x),
        .seg_end_y(seg_end_y),
        .seg_end_z(seg_end_z),
        .edge_number(edge_number),
        .last_segment(last_segment)
    );

endmodule
`default_nettype wire

// ===== tb/sv/triangle_plane_slicer_tb.sv =====
`default_nettype none
module triangle_plane_slicer_tb;
    import tps_pkg::*;

    localparam int CB = COORD_BITS;

    typedef logic signed [CB-1:0] coord_t;

    typedef struct packed {
        coord_t sx;
        coord_t sy;
        coord_t sz;
        coord_t ex;
        coord_t ey;
        coord_t ez;
        logic [EDGE_BITS-1:0] num;
        logic last;
    } segment_t;

    logic clk;
    logic rst_n;
    logic push;
    logic full;
    coord_t corner_a_x, corner_a_y, corner_a_z;
    coord_t corner_b_x, corner_b_y, corner_b_z;
    coord_t corner_c_x, corner_c_y, corner_c_z;
    logic empty;
    logic pop;
    coord_t seg_start_x, seg_start_y, seg_start_z;
    coord_t seg_end_x, seg_end_y, seg_end_z;
    logic [EDGE_BITS-1:0] edge_number;
    logic last_segment;

    triangle_plane_slicer dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .corner_a_x(corner_a_x), .corner_a_y(corner_a_y), .corner_a_z(corner_a_z),
        .corner_b_x(corner_b_x), .corner_b_y(corner_b_y), .corner_b_z(corner_b_z),
        .corner_c_x(corner_c_x), .corner_c_y(corner_c_y), .corner_c_z(corner_c_z),
        .empty(empty), .pop(pop),
        .seg_start_x(seg_start_x), .seg_start_y(seg_start_y),
        .seg_start_z(seg_start_z), .seg_end_x(seg_end_x),
        .seg_end_y(seg_end_y), .seg_end_z(seg_end_z),
        .edge_number(edge_number), .last_segment(last_segment)
    );

    segment_t expected_segments[$];
    logic [EDGE_BITS-1:0] edge_count;
    int mismatches;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_cycles;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #2 clk = ~clk;
        end
    end

    initial
    begin
        #20000000;
        $display("triangle_plane_slicer verification failed");
        $finish;
    end

    function automatic coord_t cut_coord(coord_t pv, coord_t qv, coord_t pz, coord_t qz);
        logic signed [CB+1:0] d;
        logic signed [CB+1:0] dz;
        logic signed [2*CB+3:0] num;
        logic signed [2*CB+3:0] quo;
        d = qv - pv;
        dz = qz - pz;
        if (dz == 0)
        begin
            return pv;
        end
        num = -pz * d;
        quo = num / dz;
        return coord_t'(pv + quo);
    endfunction

    task automatic add_segment(coord_t s[3], coord_t e[3], int k, logic last);
        segment_t seg;
        seg.sx = s[0];
        seg.sy = s[1];
        seg.sz = s[2];
        seg.ex = e[0];
        seg.ey = e[1];
        seg.ez = e[2];
        seg.num = edge_count + k;
        seg.last = last;
        expected_segments.push_back(seg);
    endtask

    task automatic predict_slices(coord_t c[3][3]);
        int side[3];
        int on;
        int above;
        int below;
        int lone;
        int q1;
        int q2;
        coord_t s[3];
        coord_t e[3];
        on = 0;
        above = 0;
        below = 0;
        for (int i = 0; i < 3; i++)
        begin
            if (c[i][2] > 0)
            begin
                side[i] = 1;
                above++;
            end
            else if (c[i][2] < 0)
            begin
                side[i] = -1;
                below++;
            end
            else
            begin
                side[i] = 0;
                on++;
            end
        end
        if (on == 2)
        begin
            if (side[0] != 0)
            begin
                add_segment(c[1], c[2], 0, 1'b1);
            end
            else if (side[1] != 0)
            begin
                add_segment(c[0], c[2], 0, 1'b1);
            end
            else
            begin
                add_segment(c[1], c[0], 0, 1'b1);
            end
            edge_count += 1;
        end
        else if (on == 3)
        begin
            add_segment(c[0], c[1], 0, 1'b0);
            add_segment(c[1], c[2], 1, 1'b0);
            add_segment(c[2], c[0], 2, 1'b1);
            edge_count += 3;
        end
        else if (on == 0 && above != 3 && below != 3)
        begin
            if (side[0] != side[1] && side[0] != side[2])
            begin
                lone = 0; q1 = 1; q2 = 2;
            end
            else if (side[1] != side[0])
            begin
                lone = 1; q1 = 0; q2 = 2;
            end
            else
            begin
                lone = 2; q1 = 1; q2 = 0;
            end
            for (int i = 0; i < 3; i++)
            begin
                s[i] = cut_coord(c[lone][i], c[q1][i], c[lone][2], c[q1][2]);
                e[i] = cut_coord(c[lone][i], c[q2][i], c[lone][2], c[q2][2]);
            end
            add_segment(s, e, 0, 1'b1);
            edge_count += 1;
        end
    endtask

    task automatic send_triangle(coord_t c[3][3]);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push <= 1'b1;
        corner_a_x <= c[0][0];
        corner_a_y <= c[0][1];
        corner_a_z <= c[0][2];
        corner_b_x <= c[1][0];
        corner_b_y <= c[1][1];
        corner_b_z <= c[1][2];
        corner_c_x <= c[2][0];
        corner_c_y <= c[2][1];
        corner_c_z <= c[2][2];
        do
        begin
            @(posedge clk);
        end
        while (full);
        predict_slices(c);
        @(negedge clk);
    endtask

    initial
    begin
        segment_t got;
        segment_t want;
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
            begin
                got = {seg_start_x, seg_start_y, seg_start_z, seg_end_x, seg_end_y,
                       seg_end_z, edge_number, last_segment};
                if (expected_segments.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("unexpected segment %h", got);
                    end
                end
                else
                begin
                    want = expected_segments.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("segment mismatch: expected %h actual %h", want, got);
                        end
                    end
                end
            end
        end
    end

    initial
    begin
        pop = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                pop <= 1'b0;
            end
            else
            begin
                pop <= !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
            end
        end
    end

    function automatic coord_t rand_coord();
        case ($urandom_range(5))
            0: return coord_t'($urandom);
            1: return coord_t'($urandom_range(2)) - 1;
            2: return {1'b1, {(CB-1){1'b0}}};
            3: return {1'b0, {(CB-1){1'b1}}};
            4: return coord_t'($signed($urandom_range(20000)) - 10000) <<< 8;
            default: return coord_t'($urandom) >>> $urandom_range(CB-1);
        endcase
    endfunction

    function automatic coord_t rand_z(int mode);
        coord_t v;
        v = rand_coord();
        if (v == 0)
        begin
            v = 1;
        end
        case (mode)
            0: return 0;
            1: return (v < 0) ? ~v : v;
            default: return (v > 0) ? ~v : v;
        endcase
    endfunction

    task automatic wait_drained();
        push <= 1'b0;
        while (expected_segments.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (2 * CB + 20) @(negedge clk);
    endtask

    task automatic test_directed();
        coord_t c[3][3];
        coord_t mx;
        coord_t mn;
        int zs[3];
        mx = {1'b0, {(CB-1){1'b1}}};
        mn = {1'b1, {(CB-1){1'b0}}};
        for (int combo = 0; combo < 27; combo++)
        begin
            zs[0] = combo % 3;
            zs[1] = (combo / 3) % 3;
            zs[2] = combo / 9;
            for (int i = 0; i < 3; i++)
            begin
                c[i][0] = (combo % 2) ? mx : mn;
                c[i][1] = (i == 1) ? mx : -(i + combo);
                c[i][2] = (zs[i] == 0) ? 0 : (zs[i] == 1) ? mx : mn;
            end
            send_triangle(c);
        end
    endtask

    task automatic test_random(int count);
        coord_t c[3][3];
        int mode;
        for (int n = 0; n < count; n++)
        begin
            mode = $urandom_range(9);
            for (int i = 0; i < 3; i++)
            begin
                c[i][0] = rand_coord();
                c[i][1] = rand_coord();
                if (mode < 6)
                begin
                    c[i][2] = rand_z((i == n % 3) ? 1 + (n / 3) % 2 : 2 - (n / 3) % 2);
                end
                else if (mode < 8)
                begin
                    c[i][2] = rand_z($urandom_range(2));
                end
                else
                begin
                    c[i][2] = rand_coord();
                end
            end
            send_triangle(c);
        end
    endtask

    task automatic test_backpressure();
        hold_cycles = 600;
        test_random(20);
        wait_drained();
        test_random(10);
        wait_drained();
    endtask

    initial
    begin
        rst_n = 1'b0;
        push = 1'b0;
        hold_cycles = 0;
        mismatches = 0;
        edge_count = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        {corner_a_x, corner_a_y, corner_a_z} = '0;
        {corner_b_x, corner_b_y, corner_b_z} = '0;
        {corner_c_x, corner_c_y, corner_c_z} = '0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        send_idle_pct = 34;
        recv_idle_pct = 75;
        test_directed();
        test_random(130);
        send_idle_pct = 75;
        recv_idle_pct = 34;
        test_random(130);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_backpressure();
        test_random(100);
        wait_drained();
        if (mismatches == 0 && expected_segments.size() == 0)
        begin
            $display("triangle_plane_slicer verification clean");
        end
        else
        begin
            $display("triangle_plane_slicer verification failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
